// ----- rtl/ksrc_pkg.sv -----
// Package for the keyboard scan remap and chord block: widths, codes, rule layout, job type.
// No dependencies; the RTL files use it by scoped names, the testbench files import it.
package ksrc_pkg;

    localparam int RULE_SLOTS = 4;
    localparam int CHORD_KEYS = 4;
    localparam int RULE_REGS  = 4;
    localparam int ACTIVE_SLOTS = (RULE_SLOTS < RULE_REGS) ? RULE_SLOTS : RULE_REGS;
    localparam int SLOT_W = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;

    localparam int CMD_W   = 2;
    localparam int SCAN_W  = 8;
    localparam int FLAGS_W = 16;
    localparam int UNIT_W  = 16;
    localparam int EXTRA_W = 32;
    localparam int CNT_W   = 3;
    localparam int KEY_W   = 9;
    localparam int RULE_W  = 49;
    localparam int TOT_W   = CNT_W + 1;
    localparam int IDX_W   = $clog2(2 * CHORD_KEYS);
    localparam int KSEL_W  = (CHORD_KEYS > 1) ? $clog2(CHORD_KEYS) : 1;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int DATA_W    = 64;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = REG_IDX_W + 3;

    localparam logic [CMD_W-1:0] CMD_KEY        = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CONNECT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISCONNECT = 2'd2;

    localparam int FLAG_BREAK = 0;
    localparam int FLAG_E0    = 1;

    localparam int RW_E0_BIT    = 8;
    localparam int RW_CHORD_BIT = 9;
    localparam int RW_CNT_LSB   = 10;
    localparam int RW_KEY_LSB   = 13;
    localparam int KEY_E0_BIT   = 8;

    localparam logic [REG_IDX_W-1:0] REG_RULE_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RULE_WORD0 = 3'd1;

    localparam logic [CNT_W-1:0]  RULE_COUNT_RST = 3'd1;
    localparam logic [RULE_W-1:0] RULE_A_RST     = 49'd176622392;

    typedef logic [RULE_W-1:0] rule_word_t;
    typedef logic [RULE_REGS-1:0][RULE_W-1:0] rule_bank_t;
    typedef logic [CHORD_KEYS-1:0][KEY_W-1:0] chord_keys_t;

    typedef struct packed {
        logic                 is_chord;
        logic [SCAN_W-1:0]    scan;
        logic [FLAGS_W-1:0]   flags;
        logic [UNIT_W-1:0]    unit;
        logic [EXTRA_W-1:0]   extra;
        logic [CNT_W-1:0]     cnt;
        chord_keys_t          keys;
    } job_t;

endpackage

// ----- rtl/ksrc_if.sv -----
// Valid/ready channel interfaces for key requests in and key events out.
// Depends on ksrc_pkg.
interface ksrc_in_if;
    logic                          valid;
    logic                          ready;
    logic [ksrc_pkg::CMD_W-1:0]    cmd;
    logic [ksrc_pkg::SCAN_W-1:0]   scan_code;
    logic [ksrc_pkg::FLAGS_W-1:0]  key_flags;
    logic [ksrc_pkg::UNIT_W-1:0]   unit_id;
    logic [ksrc_pkg::EXTRA_W-1:0]  extra_info;

    modport source (output valid, cmd, scan_code, key_flags, unit_id, extra_info, input ready);
    modport sink (input valid, cmd, scan_code, key_flags, unit_id, extra_info, output ready);
endinterface

interface ksrc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ksrc_pkg::SCAN_W-1:0]   out_scan;
    logic [ksrc_pkg::FLAGS_W-1:0]  out_flags;
    logic [ksrc_pkg::UNIT_W-1:0]   out_unit;
    logic [ksrc_pkg::EXTRA_W-1:0]  out_extra;
    logic                          last;

    modport source (output valid, out_scan, out_flags, out_unit, out_extra, last, input ready);
    modport sink (input valid, out_scan, out_flags, out_unit, out_extra, last, output ready);
endinterface

// ----- rtl/ksrc_front.sv -----
// Front end: accepts requests, tracks link and held chord marks, matches rules, builds jobs.
// Depends on ksrc_pkg and ksrc_in_if.
module ksrc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    ksrc_in_if.sink                       key_in,
    input  logic [ksrc_pkg::CNT_W-1:0]    rule_count,
    input  ksrc_pkg::rule_bank_t          rule_words,
    input  logic                          queue_full,
    output logic                          push,
    output ksrc_pkg::job_t                push_job
);

    logic                                 connected_reg;
    logic                                 connected_next;
    logic [ksrc_pkg::ACTIVE_SLOTS-1:0]    held_reg;
    logic [ksrc_pkg::ACTIVE_SLOTS-1:0]    held_next;
    logic                                 accept;
    logic [ksrc_pkg::CNT_W-1:0]           n_active;
    logic                                 found;
    logic [ksrc_pkg::SLOT_W-1:0]          slot;
    ksrc_pkg::rule_word_t                 word;
    logic [ksrc_pkg::ACTIVE_SLOTS-1:0]    slot_mask;
    logic                                 brk;
    logic                                 is_chord;
    logic                                 held_hit;
    logic [ksrc_pkg::CNT_W-1:0]           raw_cnt;
    logic [ksrc_pkg::CNT_W-1:0]           cnt;
    logic [ksrc_pkg::KEY_W-1:0]           key0;

    assign key_in.ready = !queue_full;
    assign accept       = key_in.valid && key_in.ready;
    assign brk          = key_in.key_flags[ksrc_pkg::FLAG_BREAK];

    always_comb
    begin
        if (rule_count > ksrc_pkg::CNT_W'(ksrc_pkg::ACTIVE_SLOTS))
        begin
            n_active = ksrc_pkg::CNT_W'(ksrc_pkg::ACTIVE_SLOTS);
        end
        else
        begin
            n_active = rule_count;
        end
    end

    always_comb
    begin
        found = 1'b0;
        slot  = '0;
        word  = '0;
        for (int i = ksrc_pkg::ACTIVE_SLOTS - 1; i >= 0; i--)
        begin
            if (ksrc_pkg::CNT_W'(i) < n_active
                && rule_words[i][ksrc_pkg::SCAN_W-1:0] == key_in.scan_code
                && rule_words[i][ksrc_pkg::RW_E0_BIT] == key_in.key_flags[ksrc_pkg::FLAG_E0])
            begin
                found = 1'b1;
                slot  = ksrc_pkg::SLOT_W'(i);
                word  = rule_words[i];
            end
        end
    end

    assign slot_mask = ksrc_pkg::ACTIVE_SLOTS'(1) << slot;
    assign is_chord  = found && word[ksrc_pkg::RW_CHORD_BIT];
    assign held_hit  = |(held_reg & slot_mask);
    assign raw_cnt   = word[ksrc_pkg::RW_CNT_LSB +: ksrc_pkg::CNT_W];
    assign cnt       = (raw_cnt > ksrc_pkg::CNT_W'(ksrc_pkg::CHORD_KEYS))
                       ? ksrc_pkg::CNT_W'(ksrc_pkg::CHORD_KEYS) : raw_cnt;
    assign key0      = word[ksrc_pkg::RW_KEY_LSB +: ksrc_pkg::KEY_W];

    always_comb
    begin
        connected_next = connected_reg;
        held_next      = held_reg;
        push           = 1'b0;
        if (accept)
        begin
            unique case (key_in.cmd)
                ksrc_pkg::CMD_CONNECT:
                begin
                    connected_next = 1'b1;
                end
                ksrc_pkg::CMD_DISCONNECT:
                begin
                    connected_next = 1'b0;
                    held_next      = '0;
                end
                ksrc_pkg::CMD_KEY:
                begin
                    if (connected_reg)
                    begin
                        if (!is_chord)
                        begin
                            push = 1'b1;
                        end
                        else if (!brk)
                        begin
                            held_next = held_reg | slot_mask;
                        end
                        else if (held_hit)
                        begin
                            held_next = held_reg & ~slot_mask;
                            push      = (cnt != '0);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        push_job.is_chord = is_chord;
        push_job.unit     = key_in.unit_id;
        push_job.extra    = key_in.extra_info;
        push_job.cnt      = cnt;
        for (int k = 0; k < ksrc_pkg::CHORD_KEYS; k++)
        begin
            push_job.keys[k] = word[ksrc_pkg::RW_KEY_LSB + ksrc_pkg::KEY_W * k +: ksrc_pkg::KEY_W];
        end
        if (found)
        begin
            push_job.scan  = key0[ksrc_pkg::SCAN_W-1:0];
            push_job.flags = ksrc_pkg::FLAGS_W'({key0[ksrc_pkg::KEY_E0_BIT], brk});
        end
        else
        begin
            push_job.scan  = key_in.scan_code;
            push_job.flags = key_in.key_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connected_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            connected_reg <= connected_next;
            held_reg      <= held_next;
        end
    end

    a_disconnect_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && key_in.cmd == ksrc_pkg::CMD_DISCONNECT |=> !connected_reg && held_reg == '0)
        else $error("disconnect left link or held marks set");

    a_no_push_offline: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> connected_reg && key_in.cmd == ksrc_pkg::CMD_KEY)
        else $error("job queued while link down or for a command");

endmodule

// ----- rtl/ksrc_queue.sv -----
// Short job queue between front end and back end.
// Depends on ksrc_pkg.
module ksrc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ksrc_pkg::job_t  push_job,
    input  logic            pop,
    output logic            full,
    output logic            q_valid,
    output ksrc_pkg::job_t  q_job
);

    ksrc_pkg::job_t                 entry_reg [ksrc_pkg::QDEPTH];
    logic [ksrc_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [ksrc_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [ksrc_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [ksrc_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [ksrc_pkg::QCNT_W-1:0]    count_reg;
    logic [ksrc_pkg::QCNT_W-1:0]    count_next;

    function automatic logic [ksrc_pkg::QPTR_W-1:0] bump(input logic [ksrc_pkg::QPTR_W-1:0] p);
        logic [ksrc_pkg::QPTR_W-1:0] r;
        if (p == ksrc_pkg::QPTR_W'(ksrc_pkg::QDEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full    = (count_reg == ksrc_pkg::QCNT_W'(ksrc_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("job queue underflow");

endmodule

// ----- rtl/ksrc_back.sv -----
// Back end: takes jobs from the queue and steps out key events through an output register.
// Depends on ksrc_pkg and ksrc_out_if.
module ksrc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  ksrc_pkg::job_t  q_job,
    output logic            pop,
    ksrc_out_if.source      key_out
);

    ksrc_pkg::job_t                 job_reg;
    logic                           job_valid_reg;
    logic                           job_valid_next;
    logic [ksrc_pkg::IDX_W-1:0]     idx_reg;
    logic [ksrc_pkg::IDX_W-1:0]     idx_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [ksrc_pkg::SCAN_W-1:0]    out_scan_reg;
    logic [ksrc_pkg::FLAGS_W-1:0]   out_flags_reg;
    logic [ksrc_pkg::UNIT_W-1:0]    out_unit_reg;
    logic [ksrc_pkg::EXTRA_W-1:0]   out_extra_reg;
    logic                           out_last_reg;
    logic                           load;
    logic                           last_step;
    logic [ksrc_pkg::TOT_W-1:0]     total;
    logic [ksrc_pkg::TOT_W-1:0]     idx_ext;
    logic [ksrc_pkg::TOT_W-1:0]     cnt_ext;
    logic                           making;
    logic [ksrc_pkg::TOT_W-1:0]     rev_idx;
    logic [ksrc_pkg::KSEL_W-1:0]    ksel;
    logic [ksrc_pkg::KEY_W-1:0]     key;
    logic [ksrc_pkg::SCAN_W-1:0]    res_scan;
    logic [ksrc_pkg::FLAGS_W-1:0]   res_flags;

    assign cnt_ext   = ksrc_pkg::TOT_W'(job_reg.cnt);
    assign total     = {job_reg.cnt, 1'b0};
    assign idx_ext   = ksrc_pkg::TOT_W'(idx_reg);
    assign making    = (idx_ext < cnt_ext);
    assign rev_idx   = total - 1'b1 - idx_ext;
    assign ksel      = making ? ksrc_pkg::KSEL_W'(idx_ext) : ksrc_pkg::KSEL_W'(rev_idx);
    assign key       = job_reg.keys[ksel];
    assign last_step = !job_reg.is_chord || (idx_ext == total - 1'b1);

    always_comb
    begin
        if (job_reg.is_chord)
        begin
            res_scan  = key[ksrc_pkg::SCAN_W-1:0];
            res_flags = ksrc_pkg::FLAGS_W'({key[ksrc_pkg::KEY_E0_BIT], !making});
        end
        else
        begin
            res_scan  = job_reg.scan;
            res_flags = job_reg.flags;
        end
    end

    assign load = job_valid_reg && (!out_valid_reg || key_out.ready);
    assign pop  = q_valid && (!job_valid_reg || (load && last_step));

    always_comb
    begin
        idx_next       = idx_reg;
        job_valid_next = job_valid_reg;
        if (load)
        begin
            idx_next = last_step ? '0 : idx_reg + 1'b1;
            if (last_step)
            begin
                job_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            job_valid_next = 1'b1;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (key_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
        end
        if (load)
        begin
            out_scan_reg  <= res_scan;
            out_flags_reg <= res_flags;
            out_unit_reg  <= job_reg.unit;
            out_extra_reg <= job_reg.extra;
            out_last_reg  <= last_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign key_out.valid     = out_valid_reg;
    assign key_out.out_scan  = out_scan_reg;
    assign key_out.out_flags = out_flags_reg;
    assign key_out.out_unit  = out_unit_reg;
    assign key_out.out_extra = out_extra_reg;
    assign key_out.last      = out_last_reg;

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && job_reg.is_chord |-> idx_ext < total)
        else $error("chord step index past end of sequence");

endmodule

// ----- rtl/keyboard_scan_remap_chord.sv -----
// Key events pass the queue entry, the back-end job register and the output register.
// Passthrough and remap give one key event; a chord release gives 2*count, one per cycle
// from the back-end step counter unless key_out stalls; commands, swallowed keys give none.
// Reset: link down, held marks clear, job queue and output empty, rule registers at defaults.
// Top level: configuration registers on the APB-style port, front end, job queue, back end.
// Depends on ksrc_pkg, ksrc_if, ksrc_front, ksrc_queue, ksrc_back.
module keyboard_scan_remap_chord (
    input  logic                            clk,
    input  logic                            rst_n,
    ksrc_in_if.sink                         key_in,
    ksrc_out_if.source                      key_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ksrc_pkg::PADDR_W-1:0]    paddr,
    input  logic [ksrc_pkg::DATA_W-1:0]     pwdata,
    output logic [ksrc_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    logic [ksrc_pkg::CNT_W-1:0]     rule_count_reg;
    ksrc_pkg::rule_bank_t           rule_words_reg;
    logic                           wr_en;
    logic [ksrc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           push;
    ksrc_pkg::job_t                 push_job;
    logic                           pop;
    logic                           queue_full;
    logic                           q_valid;
    ksrc_pkg::job_t                 q_job;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ksrc_pkg::PADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= ksrc_pkg::RULE_COUNT_RST;
        end
        else if (wr_en && reg_idx == ksrc_pkg::REG_RULE_COUNT)
        begin
            rule_count_reg <= pwdata[ksrc_pkg::CNT_W-1:0];
        end
    end

    for (genvar r = 0; r < ksrc_pkg::RULE_REGS; r++)
    begin : g_rule
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rule_words_reg[r] <= (r == 0) ? ksrc_pkg::RULE_A_RST : '0;
            end
            else if (wr_en
                     && reg_idx == ksrc_pkg::REG_IDX_W'(ksrc_pkg::REG_RULE_WORD0 + r))
            begin
                rule_words_reg[r] <= pwdata[ksrc_pkg::RULE_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = ksrc_pkg::DATA_W'(rule_count_reg);
        for (int r = 0; r < ksrc_pkg::RULE_REGS; r++)
        begin
            if (reg_idx == ksrc_pkg::REG_IDX_W'(ksrc_pkg::REG_RULE_WORD0 + r))
            begin
                prdata = ksrc_pkg::DATA_W'(rule_words_reg[r]);
            end
        end
    end

    ksrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_in     (key_in),
        .rule_count (rule_count_reg),
        .rule_words (rule_words_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    ksrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (queue_full),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    ksrc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .pop     (pop),
        .key_out (key_out)
    );

endmodule

// ----- dv/ksrc_event_checker.sv -----
`timescale 1ns / 100ps
// Checker for keyboard_scan_remap_chord: follows register writes, predicts the key events of
// every accepted request and compares them in order with the output channel.
// Depends on ksrc_pkg and ksrc_if.
module ksrc_event_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    ksrc_in_if                           key_in,
    ksrc_out_if                          key_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [ksrc_pkg::PADDR_W-1:0] paddr,
    input  logic [ksrc_pkg::DATA_W-1:0]  pwdata,
    output int                           fail_count,
    output int                           events_due
);
    import ksrc_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [SCAN_W-1:0]  scan;
        logic [FLAGS_W-1:0] flags;
        logic [UNIT_W-1:0]  unit;
        logic [EXTRA_W-1:0] extra;
        logic               last;
    } key_event_t;

    key_event_t           due_events[$];
    logic [CNT_W-1:0]     rule_limit;
    rule_bank_t           rules;
    logic [RULE_REGS-1:0] held;
    logic                 linked;
    int                   mismatches;

    function automatic key_event_t make_event(input logic [SCAN_W-1:0] scan,
                                              input logic [FLAGS_W-1:0] flags,
                                              input logic [UNIT_W-1:0] unit,
                                              input logic [EXTRA_W-1:0] extra,
                                              input logic last);
        key_event_t ev;
        ev.scan  = scan;
        ev.flags = flags;
        ev.unit  = unit;
        ev.extra = extra;
        ev.last  = last;
        return ev;
    endfunction

    function automatic logic [FLAGS_W-1:0] fresh_flags(input logic brk, input logic e0);
        logic [FLAGS_W-1:0] f;
        f = '0;
        f[FLAG_BREAK] = brk;
        f[FLAG_E0]    = e0;
        return f;
    endfunction

    task automatic predict_events(input logic [CMD_W-1:0] cmd, input logic [SCAN_W-1:0] scan,
                                  input logic [FLAGS_W-1:0] flags,
                                  input logic [UNIT_W-1:0] unit,
                                  input logic [EXTRA_W-1:0] extra);
        int               active;
        int               slot;
        int               keys;
        rule_word_t       w;
        logic [KEY_W-1:0] key;
        slot = -1;
        if (cmd == CMD_CONNECT)
            linked = 1'b1;
        else if (cmd == CMD_DISCONNECT)
        begin
            linked = 1'b0;
            held   = '0;
        end
        else if (cmd == CMD_KEY && linked)
        begin
            active = (rule_limit > ACTIVE_SLOTS) ? ACTIVE_SLOTS : int'(rule_limit);
            for (int i = 0; i < active && slot < 0; i++)
                if (rules[i][SCAN_W-1:0] == scan && rules[i][RW_E0_BIT] == flags[FLAG_E0])
                    slot = i;
            if (slot < 0)
                due_events.push_back(make_event(scan, flags, unit, extra, 1'b1));
            else
            begin
                w = rules[slot];
                if (!w[RW_CHORD_BIT])
                begin
                    key = w[RW_KEY_LSB +: KEY_W];
                    due_events.push_back(make_event(key[SCAN_W-1:0],
                        fresh_flags(flags[FLAG_BREAK], key[KEY_E0_BIT]), unit, extra, 1'b1));
                end
                else if (!flags[FLAG_BREAK])
                    held[slot] = 1'b1;
                else if (held[slot])
                begin
                    held[slot] = 1'b0;
                    keys = int'(w[RW_CNT_LSB +: CNT_W]);
                    if (keys > CHORD_KEYS)
                        keys = CHORD_KEYS;
                    for (int k = 0; k < keys; k++)
                    begin
                        key = w[RW_KEY_LSB + KEY_W * k +: KEY_W];
                        due_events.push_back(make_event(key[SCAN_W-1:0],
                            fresh_flags(1'b0, key[KEY_E0_BIT]), unit, extra, 1'b0));
                    end
                    for (int k = keys - 1; k >= 0; k--)
                    begin
                        key = w[RW_KEY_LSB + KEY_W * k +: KEY_W];
                        due_events.push_back(make_event(key[SCAN_W-1:0],
                            fresh_flags(1'b1, key[KEY_E0_BIT]), unit, extra, k == 0));
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        int         reg_idx;
        key_event_t got;
        key_event_t want;
        if (!rst_n)
        begin
            rule_limit = RULE_COUNT_RST;
            rules      = '0;
            rules[0]   = RULE_A_RST;
            held       = '0;
            linked     = 1'b0;
            mismatches = 0;
            due_events.delete();
            fail_count <= 0;
            events_due <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                reg_idx = int'(paddr[PADDR_W-1:3]);
                if (reg_idx == REG_RULE_COUNT)
                    rule_limit = pwdata[CNT_W-1:0];
                else if (reg_idx >= REG_RULE_WORD0 && reg_idx < REG_RULE_WORD0 + RULE_REGS)
                    rules[reg_idx - REG_RULE_WORD0] = pwdata[RULE_W-1:0];
            end
            if (key_in.valid && key_in.ready)
                predict_events(key_in.cmd, key_in.scan_code, key_in.key_flags,
                               key_in.unit_id, key_in.extra_info);
            if (key_out.valid && key_out.ready)
            begin
                got = make_event(key_out.out_scan, key_out.out_flags, key_out.out_unit,
                                 key_out.out_extra, key_out.last);
                if (due_events.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t unexpected key event: scan %h flags %h unit %h",
                                  " extra %h last %b"},
                                 $realtime, got.scan, got.flags, got.unit, got.extra, got.last);
                end
                else
                begin
                    want = due_events.pop_front();
                    if (got.scan !== want.scan || got.flags !== want.flags ||
                        got.unit !== want.unit || got.extra !== want.extra ||
                        got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t key event mismatch: expected scan %h flags %h unit %h",
                                      " extra %h last %b, got scan %h flags %h unit %h extra %h",
                                      " last %b"}, $realtime,
                                     want.scan, want.flags, want.unit, want.extra, want.last,
                                     got.scan, got.flags, got.unit, got.extra, got.last);
                    end
                end
            end
            fail_count <= mismatches;
            events_due <= due_events.size();
        end
    end

endmodule

// ----- dv/tb_keyboard_scan_remap_chord.sv -----
`timescale 1ns / 100ps
// Top of the keyboard_scan_remap_chord testbench: clock, reset, register writes and request
// stimulus under several idle patterns; the verdict comes from ksrc_event_checker.
// Depends on ksrc_pkg, ksrc_if, keyboard_scan_remap_chord and ksrc_event_checker.
module tb_keyboard_scan_remap_chord;
    import ksrc_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNKNOWN   = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_BEYOND    = REG_IDX_W'(REG_RULE_WORD0 + RULE_REGS);
    localparam int                   PHASES        = 6;
    localparam int                   PHASE_ITEMS   = 44;
    localparam int                   SETTLE_CYCLES = 12;
    localparam int                   IDLE_LIMIT    = 4000;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic               pready;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    int                 src_idle_pct   = 0;
    int                 sink_stall_pct = 0;
    int                 fail_count;
    int                 events_due;
    int                 items_sent = 0;
    rule_bank_t         rule_set;

    ksrc_in_if  key_in();
    ksrc_out_if key_out();

    keyboard_scan_remap_chord dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_in  (key_in),
        .key_out (key_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ksrc_event_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_in     (key_in),
        .key_out    (key_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .events_due (events_due)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        key_out.ready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SCAN_W-1:0] scan,
                                input logic [FLAGS_W-1:0] flags,
                                input logic [UNIT_W-1:0] unit,
                                input logic [EXTRA_W-1:0] extra);
        if ($urandom_range(99) < src_idle_pct)
        begin
            key_in.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        key_in.valid      <= 1'b1;
        key_in.cmd        <= cmd;
        key_in.scan_code  <= scan;
        key_in.key_flags  <= flags;
        key_in.unit_id    <= unit;
        key_in.extra_info <= extra;
        @(posedge clk);
        while (!key_in.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // send a request with random payload
    task automatic send_noise(input logic [CMD_W-1:0] cmd);
        send_request(cmd, SCAN_W'($urandom), FLAGS_W'($urandom), UNIT_W'($urandom),
                     EXTRA_W'($urandom));
    endtask

    task automatic send_key(input logic [SCAN_W-1:0] scan, input logic e0, input logic brk);
        logic [FLAGS_W-1:0] flags;
        flags = FLAGS_W'($urandom);
        flags[FLAG_BREAK] = brk;
        flags[FLAG_E0]    = e0;
        send_request(CMD_KEY, scan, flags, UNIT_W'($urandom), EXTRA_W'($urandom));
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid and hold until every predicted key event has come out
    task automatic settle();
        key_in.valid <= 1'b0;
        @(posedge clk);
        while (events_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((key_in.valid && key_in.ready) || (key_out.valid && key_out.ready) ||
                (psel && penable && pwrite && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** keyboard_scan_remap_chord: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        logic [SCAN_W-1:0] a_scan;
        logic              a_e0;
        rule_word_t        w;
        int                pick;
        int                slot;
        int                start;
        logic              paused;

        key_in.valid      = 1'b0;
        key_in.cmd        = CMD_KEY;
        key_in.scan_code  = '0;
        key_in.key_flags  = '0;
        key_in.unit_id    = '0;
        key_in.extra_info = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        a_scan = RULE_A_RST[SCAN_W-1:0];
        a_e0   = RULE_A_RST[RW_E0_BIT];

        // default rule set: one chord rule in slot 0
        send_key(a_scan, a_e0, 1'b0);
        send_noise(CMD_UNKNOWN);
        send_request(CMD_CONNECT, '0, '0, '0, '0);
        send_request(CMD_CONNECT, '1, '1, '1, '1);
        send_request(CMD_KEY, '0, '0, '0, '0);
        send_request(CMD_KEY, '1, '1, '1, '1);
        send_key(a_scan, a_e0, 1'b0);
        send_key(a_scan, a_e0, 1'b0);
        send_key(a_scan, a_e0, 1'b1);
        send_key(a_scan, a_e0, 1'b1);
        send_key(a_scan, !a_e0, 1'b0);
        send_key(a_scan, a_e0, 1'b0);
        send_noise(CMD_DISCONNECT);
        send_key(a_scan, a_e0, 1'b1);
        send_noise(CMD_CONNECT);
        send_key(a_scan, a_e0, 1'b1);
        settle();

        // remap with spare count, chord of zero keys, chord with oversized count, all-ones rule
        rule_set[0] = {9'h000, 9'h000, 9'h000, 9'h11D, 3'd3, 1'b0, 1'b0, 8'h1D};
        rule_set[1] = {9'h000, 9'h000, 9'h000, 9'h000, 3'd0, 1'b1, 1'b0, 8'h3A};
        rule_set[2] = {9'h15B, 9'h05C, 9'h138, 9'h02A, 3'd7, 1'b1, 1'b1, 8'h5B};
        rule_set[3] = '1;
        for (int k = 0; k < RULE_REGS; k++)
            write_reg(REG_IDX_W'(REG_RULE_WORD0 + k), DATA_W'(rule_set[k]));
        write_reg(REG_RULE_COUNT, DATA_W'(RULE_REGS));
        write_reg(REG_BEYOND, {$urandom, $urandom});
        send_request(CMD_KEY, 8'h1D, 16'hFFFC, UNIT_W'($urandom), EXTRA_W'($urandom));
        send_request(CMD_KEY, 8'h1D, 16'h0001, UNIT_W'($urandom), EXTRA_W'($urandom));
        send_key(8'h3A, 1'b0, 1'b0);
        send_key(8'h3A, 1'b0, 1'b1);
        send_key(8'h5B, 1'b1, 1'b0);
        send_key(8'h5B, 1'b1, 1'b1);
        send_request(CMD_KEY, 8'hFF, 16'hFFFE, UNIT_W'($urandom), EXTRA_W'($urandom));
        send_request(CMD_KEY, 8'hFF, 16'hFFFF, UNIT_W'($urandom), EXTRA_W'($urandom));

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 65;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 65;
                end
                default:
                begin
                    src_idle_pct   = 19;
                    sink_stall_pct = 19;
                end
            endcase
            for (int k = 0; k < RULE_REGS; k++)
            begin
                w = rule_word_t'({$urandom, $urandom});
                if (k > 0 && $urandom_range(3) == 0)
                    w[RW_E0_BIT:0] = rule_set[$urandom_range(k - 1)][RW_E0_BIT:0];
                rule_set[k] = w;
                write_reg(REG_IDX_W'(REG_RULE_WORD0 + k), DATA_W'(w));
            end
            case (p)
                0: write_reg(REG_RULE_COUNT, '0);
                1: write_reg(REG_RULE_COUNT, DATA_W'(3'd7));
                2: write_reg(REG_RULE_COUNT, DATA_W'(RULE_REGS));
                default: write_reg(REG_RULE_COUNT, DATA_W'($urandom_range(7)));
            endcase
            send_noise(CMD_CONNECT);
            start  = items_sent;
            paused = 1'b0;
            while (items_sent - start < PHASE_ITEMS)
            begin
                if (!paused && items_sent - start >= PHASE_ITEMS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                slot = $urandom_range(RULE_REGS - 1);
                if (pick < 6)
                    send_noise(CMD_CONNECT);
                else if (pick < 9)
                    send_noise(CMD_DISCONNECT);
                else if (pick < 11)
                    send_noise(CMD_UNKNOWN);
                else if (pick < 55)
                begin
                    repeat ($urandom_range(1, 3))
                        send_key(rule_set[slot][SCAN_W-1:0], rule_set[slot][RW_E0_BIT], 1'b0);
                    send_key(rule_set[slot][SCAN_W-1:0], rule_set[slot][RW_E0_BIT], 1'b1);
                end
                else if (pick < 75)
                    send_key(rule_set[slot][SCAN_W-1:0], rule_set[slot][RW_E0_BIT],
                             1'($urandom_range(1)));
                else
                    send_noise(CMD_KEY);
            end
        end

        settle();
        if (fail_count == 0)
            $display("** keyboard_scan_remap_chord: PASSED **");
        else
            $display("** keyboard_scan_remap_chord: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ksrc_pkg.sv
rtl/ksrc_if.sv
rtl/ksrc_front.sv
rtl/ksrc_queue.sv
rtl/ksrc_back.sv
rtl/keyboard_scan_remap_chord.sv
dv/ksrc_event_checker.sv
dv/tb_keyboard_scan_remap_chord.sv
